/* src/bts_pkg.sv */
// Shared constants, types and helper functions for the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;

    // Texture geometry
    localparam int MAX_DIM          = 64;
    localparam int WEIGHT_FRAC_BITS = 8;
    localparam int IDX_W            = $clog2(MAX_DIM);
    localparam int DIM_W            = IDX_W + 1;
    localparam int ADDR_W           = 2 * IDX_W;
    localparam int STORE_DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ROW_W            = IDX_W + DIM_W;

    // Item field widths
    localparam int IDX_IN_W   = 12;
    localparam int TEXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int NUM_TAPS   = 4;
    localparam int COORD_W    = 18;
    localparam int COORD_FRAC = 16;
    localparam int CLAMP_W    = COORD_FRAC + 1;
    localparam int SCALED_W   = CLAMP_W + IDX_W;
    localparam int OUT_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Filter arithmetic
    localparam int WGT_W     = WEIGHT_FRAC_BITS + 1;
    localparam int WPROD_W   = 2 * WEIGHT_FRAC_BITS + 1;
    localparam int ACC_W     = CHAN_W + WPROD_W + 2;
    localparam int OUT_SHIFT = 2 * WEIGHT_FRAC_BITS - CHAN_W;

    localparam logic [CLAMP_W-1:0]  COORD_ONE   = {1'b1, {COORD_FRAC{1'b0}}};
    localparam logic [WGT_W-1:0]    WGT_ONE     = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam logic [DIM_W-1:0]    DIM_MAX     = DIM_W'(MAX_DIM);
    localparam logic [IDX_IN_W:0]   DEPTH_LIMIT = (IDX_IN_W + 1)'(STORE_DEPTH);
    localparam logic [OUT_W-1:0]    CHAN_PEAK   = OUT_W'(255 * 256);

    // Opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH      = 2'd0,
        REG_TEX_HEIGHT     = 2'd1,
        REG_TEXTURE_ACTIVE = 2'd2
    } cfg_reg_t;

    // Store access issued by the address stage
    typedef struct packed {
        logic                              valid;
        logic                              is_sample;
        logic                              wr_en;
        logic [ADDR_W-1:0]                 wr_addr;
        logic [TEXEL_W-1:0]                wr_data;
        logic [NUM_TAPS-1:0][ADDR_W-1:0]   rd_addr;
        logic [WEIGHT_FRAC_BITS-1:0]       fx;
        logic [WEIGHT_FRAC_BITS-1:0]       fy;
    } tap_req_t;

    typedef logic [NUM_TAPS-1:0][TEXEL_W-1:0] quad_t;
    typedef logic [NUM_CHAN-1:0][OUT_W-1:0]   chan_t;

    // Force a dimension into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_MAX) begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    // Clamp a signed Q2.16 coordinate to 0..1.0
    function automatic logic [CLAMP_W-1:0] coord_clamp(input logic [COORD_W-1:0] c);
        logic [CLAMP_W-1:0] r;
        r = c[CLAMP_W-1:0];
        if (c[COORD_W-1]) begin
            r = '0;
        end else if (c[CLAMP_W-1:0] > COORD_ONE) begin
            r = COORD_ONE;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/bilinear_rgba8_texture_sampler_top.sv */
// Top level of the bilinear RGBA8 texture sampler with clamp-to-edge addressing.
//
// Channel   Direction  Handshake               Payload
// -------   ---------  ---------               -------
// command   in         start && !busy          opcode, texel_index, texel_rgba, u_coord, v_coord
// result    out        done (one-cycle strobe) sample_valid, red, green, blue, alpha
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// One item is accepted every cycle while busy is low. Four register stages (capture, clamp
// and scale, address with store read and weights, blend) put a sample result on the ports.
// Loads take the same path and write the store at the read stage, so a later sample sees
// them. busy is high during reset and until the first clock edge after it; the store has
// no clearing pass. The receiver cannot stall: each result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_rgba8_texture_sampler_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              opcode,
    input  wire logic [bts_pkg::IDX_IN_W-1:0]      texel_index,
    input  wire logic [bts_pkg::TEXEL_W-1:0]       texel_rgba,
    input  wire logic signed [bts_pkg::COORD_W-1:0] u_coord,
    input  wire logic signed [bts_pkg::COORD_W-1:0] v_coord,
    output logic                                   done,
    output logic                                   sample_valid,
    output logic [bts_pkg::OUT_W-1:0]              red,
    output logic [bts_pkg::OUT_W-1:0]              green,
    output logic [bts_pkg::OUT_W-1:0]              blue,
    output logic [bts_pkg::OUT_W-1:0]              alpha,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bts_pkg::*;

    logic              busy_reg;
    logic [DIM_W-1:0]  tex_width_reg;
    logic [DIM_W-1:0]  tex_height_reg;
    logic              texture_active_reg;
    logic              accept;
    tap_req_t          req;
    quad_t             texels;
    chan_t             chans;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    // Hold off items until the cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg      <= DIM_MAX;
            tex_height_reg     <= DIM_MAX;
            texture_active_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEX_WIDTH:      tex_width_reg      <= cfg_data[DIM_W-1:0];
                REG_TEX_HEIGHT:     tex_height_reg     <= cfg_data[DIM_W-1:0];
                REG_TEXTURE_ACTIVE: texture_active_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    bts_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (opcode),
        .texel_index (texel_index),
        .texel_rgba  (texel_rgba),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .tex_width   (tex_width_reg),
        .tex_height  (tex_height_reg),
        .req         (req)
    );

    bts_store u_store (
        .clk    (clk),
        .req    (req),
        .texels (texels)
    );

    bts_blend u_blend (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .texels         (texels),
        .texture_active (texture_active_reg),
        .done           (done),
        .sample_valid   (sample_valid),
        .chans          (chans)
    );

    assign red   = chans[0];
    assign green = chans[1];
    assign blue  = chans[2];
    assign alpha = chans[3];

    // Every accepted sample yields a result strobe, and every strobe follows an accepted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && opcode == OP_SAMPLE, 4))
        else $error("result strobe without a sample accepted four cycles earlier");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy && opcode == OP_SAMPLE, 4) |-> done)
        else $error("accepted sample produced no result");

    // Result validity follows the bound-texture flag
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sample_valid == texture_active_reg))
        else $error("sample_valid disagrees with texture_active");

    // Normalised weights keep every channel within texel scale
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (red <= CHAN_PEAK && green <= CHAN_PEAK
                  && blue <= CHAN_PEAK && alpha <= CHAN_PEAK))
        else $error("filtered channel exceeds full scale");

endmodule
`default_nettype wire

/* src/bts_addr.sv */
// Coordinate clamp, scaling and neighbour address generation (two stages).
`timescale 1ns / 1ps
`default_nettype none
module bts_addr (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            opcode,
    input  wire logic [bts_pkg::IDX_IN_W-1:0]    texel_index,
    input  wire logic [bts_pkg::TEXEL_W-1:0]     texel_rgba,
    input  wire logic [bts_pkg::COORD_W-1:0]     u_coord,
    input  wire logic [bts_pkg::COORD_W-1:0]     v_coord,
    input  wire logic [bts_pkg::DIM_W-1:0]       tex_width,
    input  wire logic [bts_pkg::DIM_W-1:0]       tex_height,
    output bts_pkg::tap_req_t                    req
);
    import bts_pkg::*;

    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [IDX_IN_W-1:0]   s1_index_reg;
    logic [TEXEL_W-1:0]    s1_rgba_reg;
    logic [COORD_W-1:0]    s1_u_reg;
    logic [COORD_W-1:0]    s1_v_reg;

    logic                  s2_valid_reg;
    logic                  s2_op_reg;
    logic                  s2_wr_en_reg;
    logic [ADDR_W-1:0]     s2_index_reg;
    logic [TEXEL_W-1:0]    s2_rgba_reg;
    logic [SCALED_W-1:0]   s2_xs_reg;
    logic [SCALED_W-1:0]   s2_ys_reg;

    logic [DIM_W-1:0]      w_sat;
    logic [DIM_W-1:0]      h_sat;
    logic [DIM_W-1:0]      wm1_full;
    logic [DIM_W-1:0]      hm1_full;
    logic [CLAMP_W-1:0]    cu;
    logic [CLAMP_W-1:0]    cv;
    logic [SCALED_W-1:0]   s2_xs_next;
    logic [SCALED_W-1:0]   s2_ys_next;
    logic                  s2_wr_en_next;

    logic [IDX_W-1:0]      x0;
    logic [IDX_W-1:0]      x1;
    logic [IDX_W-1:0]      y0;
    logic [IDX_W-1:0]      y1;
    logic [DIM_W-1:0]      x0_inc;
    logic [DIM_W-1:0]      y0_inc;
    logic [ROW_W-1:0]      row0;
    logic [ROW_W-1:0]      row1;
    logic [ROW_W-1:0]      pos [NUM_TAPS];

    // Capture the item on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= opcode;
            s1_index_reg <= texel_index;
            s1_rgba_reg  <= texel_rgba;
            s1_u_reg     <= u_coord;
            s1_v_reg     <= v_coord;
        end
    end

    // Clamp and scale both coordinates by dimension minus one
    always_comb
    begin
        w_sat         = dim_sat(tex_width);
        h_sat         = dim_sat(tex_height);
        wm1_full      = w_sat - DIM_W'(1);
        hm1_full      = h_sat - DIM_W'(1);
        cu            = coord_clamp(s1_u_reg);
        cv            = coord_clamp(s1_v_reg);
        s2_xs_next    = SCALED_W'(cu) * SCALED_W'(wm1_full[IDX_W-1:0]);
        s2_ys_next    = SCALED_W'(cv) * SCALED_W'(hm1_full[IDX_W-1:0]);
        s2_wr_en_next = (s1_op_reg == OP_LOAD) && ({1'b0, s1_index_reg} < DEPTH_LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_wr_en_reg <= s2_wr_en_next;
            s2_index_reg <= s1_index_reg[ADDR_W-1:0];
            s2_rgba_reg  <= s1_rgba_reg;
            s2_xs_reg    <= s2_xs_next;
            s2_ys_reg    <= s2_ys_next;
        end
    end

    // Split into integer position and weight fraction, clamp the far neighbour
    always_comb
    begin
        x0     = s2_xs_reg[COORD_FRAC +: IDX_W];
        y0     = s2_ys_reg[COORD_FRAC +: IDX_W];
        x0_inc = {1'b0, x0} + DIM_W'(1);
        y0_inc = {1'b0, y0} + DIM_W'(1);
        x1     = (x0_inc < w_sat) ? x0_inc[IDX_W-1:0] : x0;
        y1     = (y0_inc < h_sat) ? y0_inc[IDX_W-1:0] : y0;
        row0   = ROW_W'(y0) * ROW_W'(w_sat);
        row1   = ROW_W'(y1) * ROW_W'(w_sat);
        pos[0] = row0 + ROW_W'(x0);
        pos[1] = row0 + ROW_W'(x1);
        pos[2] = row1 + ROW_W'(x0);
        pos[3] = row1 + ROW_W'(x1);
    end

    // Drive the store request
    always_comb
    begin
        req.valid     = s2_valid_reg;
        req.is_sample = (s2_op_reg == OP_SAMPLE);
        req.wr_en     = s2_wr_en_reg;
        req.wr_addr   = s2_index_reg;
        req.wr_data   = s2_rgba_reg;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            req.rd_addr[k] = pos[k][ADDR_W-1:0];
        end
        req.fx = s2_xs_reg[COORD_FRAC-WEIGHT_FRAC_BITS +: WEIGHT_FRAC_BITS];
        req.fy = s2_ys_reg[COORD_FRAC-WEIGHT_FRAC_BITS +: WEIGHT_FRAC_BITS];
    end

endmodule
`default_nettype wire

/* src/bts_store.sv */
// Texel store: two mirrored memories, each one write port and two read ports.
`timescale 1ns / 1ps
`default_nettype none
module bts_store (
    input  wire logic             clk,
    input  wire bts_pkg::tap_req_t req,
    output bts_pkg::quad_t         texels
);
    import bts_pkg::*;

    // Upper row neighbours come from one copy, lower row neighbours from the other
    logic [TEXEL_W-1:0] mem_top [STORE_DEPTH];
    logic [TEXEL_W-1:0] mem_bot [STORE_DEPTH];
    quad_t              texel_reg;

    // Write both copies on a load
    always_ff @(posedge clk)
    begin
        if (req.valid && req.wr_en)
        begin
            mem_top[req.wr_addr] <= req.wr_data;
            mem_bot[req.wr_addr] <= req.wr_data;
        end
    end

    // Fetch all four neighbours of a sample in the same cycle
    always_ff @(posedge clk)
    begin
        if (req.valid && req.is_sample)
        begin
            texel_reg[0] <= mem_top[req.rd_addr[0]];
            texel_reg[1] <= mem_top[req.rd_addr[1]];
            texel_reg[2] <= mem_bot[req.rd_addr[2]];
            texel_reg[3] <= mem_bot[req.rd_addr[3]];
        end
    end

    assign texels = texel_reg;

endmodule
`default_nettype wire

/* src/bts_blend.sv */
// Bilinear weights, per-channel weighted sum and result register.
`timescale 1ns / 1ps
`default_nettype none
module bts_blend (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bts_pkg::tap_req_t req,
    input  wire bts_pkg::quad_t    texels,
    input  wire logic              texture_active,
    output logic                   done,
    output logic                   sample_valid,
    output bts_pkg::chan_t         chans
);
    import bts_pkg::*;

    logic [WGT_W-1:0]    wx [2];
    logic [WGT_W-1:0]    wy [2];
    logic [2*WGT_W-1:0]  wprod [NUM_TAPS];

    logic                s3_valid_reg;
    logic [WPROD_W-1:0]  s3_wgt_reg [NUM_TAPS];

    logic [ACC_W-1:0]    acc [NUM_CHAN];
    chan_t               chan_next;

    logic                done_reg;
    logic                sample_valid_reg;
    chan_t               chan_reg;

    // Form the four tap weights alongside the store read
    always_comb
    begin
        wx[0] = WGT_ONE - {1'b0, req.fx};
        wx[1] = {1'b0, req.fx};
        wy[0] = WGT_ONE - {1'b0, req.fy};
        wy[1] = {1'b0, req.fy};
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            wprod[k] = (2*WGT_W)'(wx[k % 2]) * (2*WGT_W)'(wy[k / 2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= req.valid && req.is_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.is_sample)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                s3_wgt_reg[k] <= wprod[k][WPROD_W-1:0];
            end
        end
    end

    // Weighted sum per channel, truncate to eight fraction bits; zero while texture_active is low
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc[c] = '0;
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                acc[c] = acc[c] + ACC_W'(texels[k][c*CHAN_W +: CHAN_W])
                                * ACC_W'(s3_wgt_reg[k]);
            end
            chan_next[c] = texture_active ? acc[c][OUT_SHIFT +: OUT_W] : '0;
        end
    end

    // Present the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            sample_valid_reg <= texture_active;
            chan_reg         <= chan_next;
        end
    end

    assign done         = done_reg;
    assign sample_valid = sample_valid_reg;
    assign chans        = chan_reg;

endmodule
`default_nettype wire
